@@ sv/cgt_pkg.sv @@
// Package: shared constants and types for the CSR graph transpose block.
`default_nettype none
package cgt_pkg;
	localparam int MaxVertices = 1024;
	localparam int MaxEdges    = 4096;
	localparam int WeightBits  = 32;

	localparam logic [1:0] ModeLoad  = 2'd0;
	localparam logic [1:0] ModeBuild = 2'd1;
	localparam logic [1:0] ModeRdOff = 2'd2;
	localparam logic [1:0] ModeRdEdg = 2'd3;

	localparam logic [1:0] StatOk    = 2'd0;
	localparam logic [1:0] StatRange = 2'd1;
	localparam logic [1:0] StatNoBld = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PFX_RD,
		ST_PFX_WR,
		ST_SCT_RD,
		ST_SCT_LK,
		ST_SCT_WR,
		ST_CLR,
		ST_READ,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

@@ sv/csr_graph_transpose.sv @@
// Top level: CSR graph transpose with counting sort under a small sequencer.
//
// Channel   Direction  Handshake             Words
// cfg       in         cfg_valid/cfg_ready   vertex_count
// command   in         start/busy            mode, src_vertex, dst_vertex, edge_weight, read_index
// result    out        done strobe           status, read_value, read_weight
//
// A load or read ends with the done strobe; a load goes through the registered
// read port of the degree memory, a read through that of the offset or edge
// store. A build walks the degree memory once (PFX_RD then PFX_WR for each
// vertex, plus the closing offset), the edge list once (SCT_RD, SCT_WR and
// SCT_LK for each edge; an edge outside the vertex count skips SCT_LK) and then
// clears all MAX_VERTICES counters. A build while already built skips to DONE.
// Reset clears control only; the degree and fill memories are cleared by that
// same clearing pass, run once after reset with busy high.
// The receiver cannot stall: done lasts exactly one cycle.
`default_nettype none
module csr_graph_transpose #(
	parameter int MAX_VERTICES = cgt_pkg::MaxVertices,
	parameter int MAX_EDGES    = cgt_pkg::MaxEdges,
	parameter int WEIGHT_BITS  = cgt_pkg::WeightBits
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] vertex_count,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [9:0]  src_vertex,
	input  wire logic [9:0]  dst_vertex,
	input  wire logic [31:0] edge_weight,
	input  wire logic [12:0] read_index,
	output logic             done,
	output logic [1:0]       status,
	output logic [12:0]      read_value,
	output logic [31:0]      read_weight
);
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int CW = EW + 1;
	localparam int VCW = VW + 1;

	cgt_pkg::state_t state_q, state_d;

	// vertex count register, clamped on write
	logic [VCW-1:0] vc_q;
	logic [10:0] cfg_clamped;
	always_comb begin
		if (vertex_count == 11'd0) cfg_clamped = 11'd1;
		else if ({21'd0, vertex_count} > MAX_VERTICES) cfg_clamped = 11'(MAX_VERTICES);
		else cfg_clamped = vertex_count;
	end
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_q <= VCW'(MAX_VERTICES);
		else if (cfg_valid) vc_q <= VCW'(cfg_clamped);
	end

	// command capture
	logic [1:0] mode_q;
	logic [9:0] src_q, dst_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [12:0] idx_q;

	// control state
	logic [CW-1:0] ecount_q, btotal_q;
	logic [VCW-1:0] bvc_q, bvc_cur_q;
	logic built_q;
	logic [CW-1:0] iter_q, iter_d;
	logic [12:0] run_q, run_d;

	// memories
	logic [12:0] deg_mem [MAX_VERTICES];
	logic [12:0] fill_mem [MAX_VERTICES];
	logic [12:0] off_mem [MAX_VERTICES+1];
	logic [9:0] ssrc_mem [MAX_EDGES];
	logic [9:0] sdst_mem [MAX_EDGES];
	logic [WEIGHT_BITS-1:0] sw_mem [MAX_EDGES];
	logic [9:0] ot_mem [MAX_EDGES];
	logic [WEIGHT_BITS-1:0] ow_mem [MAX_EDGES];

	// registered read data
	logic [12:0] deg_rd_q, fill_rd_q, off_rd_q;
	logic [9:0] ssrc_rd_q, sdst_rd_q, ot_rd_q;
	logic [WEIGHT_BITS-1:0] sw_rd_q, ow_rd_q;

	// control strobes
	logic deg_we, fill_we, off_we, st_we, out_we;
	logic [VW-1:0] deg_ra, deg_wa;
	logic [12:0] deg_wd, fill_wd;
	logic [VW:0] off_ra, off_wa;
	logic [12:0] off_wd;
	logic [EW-1:0] st_ra, ot_ra, out_wa;
	logic [1:0] stat_d;
	logic [12:0] val_d;
	logic [31:0] wt_d;
	logic done_d;
	logic load_ok;
	logic [12:0] pos;

	assign load_ok = (ecount_q < CW'(MAX_EDGES)) && ({1'b0, src_q} < 11'(vc_q))
		&& ({1'b0, dst_q} < 11'(vc_q));
	assign pos = off_rd_q + fill_rd_q;

	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		deg_rd_q <= deg_mem[deg_ra];
		if (fill_we) fill_mem[deg_wa] <= fill_wd;
		fill_rd_q <= fill_mem[deg_ra];
		if (off_we) off_mem[off_wa] <= off_wd;
		off_rd_q <= off_mem[off_ra];
		if (st_we) begin
			ssrc_mem[ecount_q[EW-1:0]] <= src_q;
			sdst_mem[ecount_q[EW-1:0]] <= dst_q;
			sw_mem[ecount_q[EW-1:0]] <= w_q;
		end
		ssrc_rd_q <= ssrc_mem[st_ra];
		sdst_rd_q <= sdst_mem[st_ra];
		sw_rd_q <= sw_mem[st_ra];
		if (out_we) begin
			ot_mem[out_wa] <= ssrc_rd_q;
			ow_mem[out_wa] <= sw_rd_q;
		end
		ot_rd_q <= ot_mem[ot_ra];
		ow_rd_q <= ow_mem[ot_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cgt_pkg::ModeLoad;
			src_q <= '0;
			dst_q <= '0;
			w_q <= '0;
			idx_q <= '0;
		end else if (start && !busy) begin
			mode_q <= mode;
			src_q <= src_vertex;
			dst_q <= dst_vertex;
			w_q <= WEIGHT_BITS'(edge_weight);
			idx_q <= read_index;
		end
	end

	always_comb begin
		state_d = state_q;
		iter_d = iter_q;
		run_d = run_q;
		deg_we = 1'b0; fill_we = 1'b0; off_we = 1'b0; st_we = 1'b0; out_we = 1'b0;
		deg_ra = dst_q[VW-1:0];
		deg_wa = dst_q[VW-1:0];
		deg_wd = deg_rd_q + 13'd1;
		fill_wd = fill_rd_q + 13'd1;
		off_ra = idx_q[VW:0];
		off_wa = '0;
		off_wd = run_q;
		st_ra = iter_q[EW-1:0];
		ot_ra = idx_q[EW-1:0];
		out_wa = pos[EW-1:0];
		stat_d = cgt_pkg::StatOk;
		val_d = '0;
		wt_d = '0;
		done_d = 1'b0;
		unique case (state_q)
			cgt_pkg::ST_IDLE: begin
				if (start) begin
					unique case (mode)
						cgt_pkg::ModeLoad: state_d = cgt_pkg::ST_LOAD;
						cgt_pkg::ModeBuild: begin
							if (built_q) state_d = cgt_pkg::ST_DONE;
							else begin
								state_d = cgt_pkg::ST_PFX_RD;
								iter_d = '0;
								run_d = '0;
							end
						end
						default: state_d = cgt_pkg::ST_READ;
					endcase
				end
			end
			cgt_pkg::ST_LOAD: begin
				// read degree at dst_q; data lands for SCT_LK
				state_d = cgt_pkg::ST_SCT_LK;
			end
			cgt_pkg::ST_PFX_RD: begin
				// write running sum at index iter; read degree of iter
				deg_ra = iter_q[VW-1:0];
				off_we = 1'b1;
				off_wa = iter_q[VW:0];
				off_wd = run_q;
				if (iter_q >= CW'(bvc_cur_q)) begin
					state_d = cgt_pkg::ST_SCT_RD;
					iter_d = '0;
				end else state_d = cgt_pkg::ST_PFX_WR;
			end
			cgt_pkg::ST_PFX_WR: begin
				run_d = run_q + deg_rd_q;
				iter_d = iter_q + CW'(1);
				state_d = cgt_pkg::ST_PFX_RD;
			end
			cgt_pkg::ST_SCT_RD: begin
				st_ra = iter_q[EW-1:0];
				if (iter_q >= ecount_q) begin
					state_d = cgt_pkg::ST_CLR;
					iter_d = '0;
				end else state_d = cgt_pkg::ST_SCT_WR;
			end
			cgt_pkg::ST_SCT_WR: begin
				// edge words now registered; look up offset and fill
				deg_ra = sdst_rd_q[VW-1:0];
				off_ra = {1'b0, sdst_rd_q[VW-1:0]};
				st_ra = iter_q[EW-1:0];
				if ({1'b0, sdst_rd_q} < 11'(bvc_cur_q)) state_d = cgt_pkg::ST_SCT_LK;
				else begin
					// drop an edge outside the vertex count
					iter_d = iter_q + CW'(1);
					state_d = cgt_pkg::ST_SCT_RD;
				end
			end
			cgt_pkg::ST_SCT_LK: begin
				if (mode_q == cgt_pkg::ModeLoad) begin
					// finish a load: store edge and bump degree, or flag a range error
					if (load_ok) begin
						st_we = 1'b1;
						deg_we = 1'b1;
					end else stat_d = cgt_pkg::StatRange;
					done_d = 1'b1;
					state_d = cgt_pkg::ST_IDLE;
				end else begin
					deg_wa = sdst_rd_q[VW-1:0];
					fill_we = 1'b1;
					out_we = pos < 13'(MAX_EDGES);
					st_ra = iter_q[EW-1:0];
					iter_d = iter_q + CW'(1);
					state_d = cgt_pkg::ST_SCT_RD;
				end
			end
			cgt_pkg::ST_CLR: begin
				deg_we = 1'b1; fill_we = 1'b1;
				deg_wa = iter_q[VW-1:0];
				deg_wd = '0; fill_wd = '0;
				iter_d = iter_q + CW'(1);
				if (iter_q == CW'(MAX_VERTICES - 1)) begin
					state_d = (mode_q == cgt_pkg::ModeBuild) ? cgt_pkg::ST_DONE
						: cgt_pkg::ST_IDLE;
				end
			end
			cgt_pkg::ST_READ: begin
				state_d = cgt_pkg::ST_DONE;
			end
			cgt_pkg::ST_DONE: begin
				done_d = 1'b1;
				state_d = cgt_pkg::ST_IDLE;
				if (mode_q == cgt_pkg::ModeRdOff || mode_q == cgt_pkg::ModeRdEdg) begin
					if (!built_q) stat_d = cgt_pkg::StatNoBld;
					else if (mode_q == cgt_pkg::ModeRdOff) begin
						if (idx_q <= 13'(bvc_q) && {19'd0, idx_q} <= MAX_VERTICES)
							val_d = off_rd_q;
						else stat_d = cgt_pkg::StatRange;
					end else begin
						if (CW'(idx_q) < btotal_q && {19'd0, idx_q} < MAX_EDGES
							&& idx_q[12:0] < 13'(MAX_EDGES)) begin
							val_d = 13'(ot_rd_q);
							wt_d = 32'(ow_rd_q);
						end else stat_d = cgt_pkg::StatRange;
					end
				end
			end
			default: state_d = cgt_pkg::ST_IDLE;
		endcase
	end

	// state register; reset starts with the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cgt_pkg::ST_CLR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			run_q <= '0;
			ecount_q <= '0;
			btotal_q <= '0;
			bvc_q <= '0;
			bvc_cur_q <= '0;
			built_q <= 1'b0;
			done <= 1'b0;
			status <= '0;
			read_value <= '0;
			read_weight <= '0;
		end else begin
			iter_q <= iter_d;
			run_q <= run_d;
			done <= done_d;
			status <= stat_d;
			read_value <= val_d;
			read_weight <= wt_d;
			if (state_q == cgt_pkg::ST_IDLE && start) begin
				bvc_cur_q <= vc_q;
				if (mode == cgt_pkg::ModeLoad && built_q) begin
					built_q <= 1'b0;
					ecount_q <= '0;
				end
			end
			if (st_we) ecount_q <= ecount_q + CW'(1);
			if (state_q == cgt_pkg::ST_CLR && iter_q == CW'(MAX_VERTICES - 1)
				&& mode_q == cgt_pkg::ModeBuild && !built_q) begin
				built_q <= 1'b1;
				bvc_q <= bvc_cur_q;
				btotal_q <= CW'(run_q);
			end
		end
	end

	assign busy = (state_q != cgt_pkg::ST_IDLE);
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for csr_graph_transpose: directed and random command streams checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	typedef struct {
		logic [1:0]  mode;
		logic [9:0]  src;
		logic [9:0]  dst;
		logic [31:0] wt;
		logic [12:0] idx;
		bit          hold;  // wait for every outstanding result before issuing
	} cmd_t;

	typedef struct {
		logic [1:0]  status;
		logic [12:0] value;
		logic [31:0] weight;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] vertex_count = 11'd1024;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = cgt_pkg::ModeLoad;
	logic [9:0]  src_vertex = '0;
	logic [9:0]  dst_vertex = '0;
	logic [31:0] edge_weight = '0;
	logic [12:0] read_index = '0;
	logic        done;
	logic [1:0]  status;
	logic [12:0] read_value;
	logic [31:0] read_weight;

	csr_graph_transpose dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .vertex_count(vertex_count),
		.start(start), .busy(busy), .mode(mode), .src_vertex(src_vertex),
		.dst_vertex(dst_vertex), .edge_weight(edge_weight), .read_index(read_index),
		.done(done), .status(status), .read_value(read_value), .read_weight(read_weight)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Predicted block state, mirrored one command at a time.
	int unsigned vc_now = cgt_pkg::MaxVertices;
	int unsigned deg_cnt [cgt_pkg::MaxVertices];
	int unsigned fill_cnt [cgt_pkg::MaxVertices];
	int unsigned row_offs [cgt_pkg::MaxVertices + 1];
	logic [9:0]  edge_src [cgt_pkg::MaxEdges];
	logic [9:0]  edge_dst [cgt_pkg::MaxEdges];
	logic [31:0] edge_wt [cgt_pkg::MaxEdges];
	logic [9:0]  tr_target [cgt_pkg::MaxEdges];
	logic [31:0] tr_weight [cgt_pkg::MaxEdges];
	int unsigned edges_held = 0;
	bit          is_built = 0;
	int unsigned built_vc = 0;
	int unsigned built_total = 0;

	cmd_t   pend_q [$];
	reply_t reply_q [$];
	cmd_t   cur;
	int     gap_left = 0;
	bit     no_gap = 0;
	int     errors = 0;
	int     issued = 0;

	initial begin
		for (int i = 0; i < cgt_pkg::MaxVertices; i++) begin
			deg_cnt[i] = 0;
			fill_cnt[i] = 0;
		end
	end

	// Work out the reply to one accepted command and advance the mirrored state.
	function automatic reply_t transpose_step(cmd_t c);
		reply_t r;
		int unsigned run, pos;
		r.status = cgt_pkg::StatOk;
		r.value = '0;
		r.weight = '0;
		case (c.mode)
			cgt_pkg::ModeLoad: begin
				if (is_built) begin
					is_built = 0;
					edges_held = 0;
				end
				if (edges_held >= cgt_pkg::MaxEdges || c.src >= vc_now || c.dst >= vc_now) begin
					r.status = cgt_pkg::StatRange;
				end else begin
					edge_src[edges_held] = c.src;
					edge_dst[edges_held] = c.dst;
					edge_wt[edges_held] = c.wt;
					edges_held++;
					deg_cnt[c.dst]++;
				end
			end
			cgt_pkg::ModeBuild: begin
				if (!is_built) begin
					// prefix sum over the in-degrees, then a stable scatter
					run = 0;
					row_offs[0] = 0;
					for (int v = 0; v < vc_now; v++) begin
						run += deg_cnt[v];
						row_offs[v + 1] = run;
					end
					for (int e = 0; e < edges_held; e++) begin
						if (edge_dst[e] < vc_now) begin
							pos = row_offs[edge_dst[e]] + fill_cnt[edge_dst[e]];
							fill_cnt[edge_dst[e]]++;
							if (pos < cgt_pkg::MaxEdges) begin
								tr_target[pos] = edge_src[e];
								tr_weight[pos] = edge_wt[e];
							end
						end
					end
					for (int v = 0; v < cgt_pkg::MaxVertices; v++) begin
						deg_cnt[v] = 0;
						fill_cnt[v] = 0;
					end
					built_vc = vc_now;
					built_total = run;
					is_built = 1;
				end
			end
			default: begin
				if (!is_built) begin
					r.status = cgt_pkg::StatNoBld;
				end else if (c.mode == cgt_pkg::ModeRdOff) begin
					if (c.idx <= built_vc && c.idx <= cgt_pkg::MaxVertices)
						r.value = 13'(row_offs[c.idx]);
					else r.status = cgt_pkg::StatRange;
				end else begin
					if (c.idx < built_total && c.idx < cgt_pkg::MaxEdges) begin
						r.value = {3'b000, tr_target[c.idx]};
						r.weight = tr_weight[c.idx];
					end else begin
						r.status = cgt_pkg::StatRange;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gap || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver: hold start until the word is taken, then pop the next one after its gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin : drive
			cmd_t c;
			logic go;
			go = start;
			if (start && !busy) begin
				reply_q.push_back(transpose_step(cur));
				go = 1'b0;
			end
			if (!go) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pend_q.size() > 0 && (!pend_q[0].hold || reply_q.size() == 0)) begin
					c = pend_q.pop_front();
					cur <= c;
					mode <= c.mode;
					src_vertex <= c.src;
					dst_vertex <= c.dst;
					edge_weight <= c.wt;
					read_index <= c.idx;
					go = 1'b1;
					gap_left <= pick_gap();
				end
			end
			start <= go;
		end
	end

	// Track the register as the block sees it, clamped to 1..MaxVertices.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			if (vertex_count == 0) vc_now <= 1;
			else if (vertex_count > cgt_pkg::MaxVertices) vc_now <= cgt_pkg::MaxVertices;
			else vc_now <= {21'd0, vertex_count};
		end
	end

	// Monitor: every done strobe must match the oldest predicted reply.
	always @(posedge clk) begin
		if (arst_n && done) begin : check
			reply_t e;
			if (reply_q.size() == 0) begin
				$error("unexpected result word: status %0d value %0d weight %h",
					status, read_value, read_weight);
				errors++;
			end else begin
				e = reply_q.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, status);
					errors++;
				end
				if (read_value !== e.value) begin
					$error("read_value: expected %0d, actual %0d", e.value, read_value);
					errors++;
				end
				if (read_weight !== e.weight) begin
					$error("read_weight: expected %h, actual %h", e.weight, read_weight);
					errors++;
				end
			end
		end
	end

	task automatic push_cmd(logic [1:0] m, logic [9:0] s, logic [9:0] d, logic [31:0] w,
			logic [12:0] i, bit h = 0);
		cmd_t c;
		c.mode = m;
		c.src = s;
		c.dst = d;
		c.wt = w;
		c.idx = i;
		c.hold = h;
		pend_q.push_back(c);
		issued++;
	endtask

	task automatic load(int s, int d, logic [31:0] w);
		push_cmd(cgt_pkg::ModeLoad, 10'(s), 10'(d), w, 13'($urandom));
	endtask

	task automatic read(logic [1:0] m, int i);
		push_cmd(m, 10'($urandom), 10'($urandom), $urandom, 13'(i));
	endtask

	// Drain everything, then allow the block to settle before touching the register.
	task automatic wait_idle();
		while (pend_q.size() > 0 || reply_q.size() > 0 || start) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_vc(logic [10:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		vertex_count <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int n, s, pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reads before any build, then a build of an empty graph
		read(cgt_pkg::ModeRdOff, 0);
		read(cgt_pkg::ModeRdEdg, 8191);
		push_cmd(cgt_pkg::ModeBuild, 0, 0, 0, 0);
		read(cgt_pkg::ModeRdOff, 0);
		read(cgt_pkg::ModeRdOff, 1024);
		read(cgt_pkg::ModeRdOff, 1025);
		read(cgt_pkg::ModeRdEdg, 0);
		// field extremes, an edge out of row order, a read after the graph restarts
		load(0, 1023, 32'h0000_0000);
		load(1023, 0, 32'hFFFF_FFFF);
		load(1023, 1023, 32'hA5A5_5A5A);
		load(5, 3, 32'h5A5A_A5A5);
		read(cgt_pkg::ModeRdEdg, 0);
		push_cmd(cgt_pkg::ModeBuild, 0, 0, 0, 0);
		push_cmd(cgt_pkg::ModeBuild, 0, 0, 0, 0);
		for (int i = 0; i < 5; i++) read(cgt_pkg::ModeRdEdg, i);
		read(cgt_pkg::ModeRdOff, 1);
		read(cgt_pkg::ModeRdOff, 1023);
		read(cgt_pkg::ModeRdOff, 1024);

		// zero acts as one vertex; an edge outside it is refused with a range status
		write_vc(11'd0);
		load(0, 0, 32'h1234_5678);
		load(1, 0, 32'h1);
		load(0, 1, 32'h2);
		push_cmd(cgt_pkg::ModeBuild, 0, 0, 0, 0);
		read(cgt_pkg::ModeRdOff, 1);
		read(cgt_pkg::ModeRdOff, 2);
		read(cgt_pkg::ModeRdEdg, 0);
		read(cgt_pkg::ModeRdEdg, 1);

		// shrink the vertex count between loading and building
		write_vc(11'd2047);
		load(2, 900, $urandom);
		load(3, 10, $urandom);
		load(700, 10, $urandom);
		write_vc(11'd500);
		push_cmd(cgt_pkg::ModeBuild, 0, 0, 0, 0);
		read(cgt_pkg::ModeRdEdg, 0);
		read(cgt_pkg::ModeRdEdg, 1);
		read(cgt_pkg::ModeRdEdg, 2);
		read(cgt_pkg::ModeRdOff, 500);
		read(cgt_pkg::ModeRdOff, 501);

		// back-to-back loads, then a load that waits for every result
		write_vc(11'd1024);
		no_gap = 1;
		for (int i = 0; i < 64; i++) load(i / 4, $urandom_range(0, 1023), $urandom);
		push_cmd(cgt_pkg::ModeLoad, 7, 7, $urandom, 0, 1);
		load(1023, 1023, $urandom);
		push_cmd(cgt_pkg::ModeBuild, 0, 0, 0, 0);
		for (int i = 0; i < 20; i++) read(cgt_pkg::ModeRdEdg, $urandom_range(0, 70));
		read(cgt_pkg::ModeRdEdg, 65);
		read(cgt_pkg::ModeRdEdg, 66);
		read(cgt_pkg::ModeRdOff, 1024);
		no_gap = 0;

		// random graphs: row-ordered loads, a build, then reads, with some noise
		while (issued < 1450) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: write_vc(11'd1);
				1: write_vc(11'd1024);
				2: write_vc(11'($urandom_range(1025, 2047)));
				3: write_vc(11'd0);
				4: write_vc(11'd2);
				default: write_vc(11'($urandom_range(1, 1024)));
			endcase
			no_gap = ($urandom_range(0, 3) == 0);
			n = $urandom_range(0, 40);
			s = $urandom_range(0, vc_now - 1);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					load($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
				end else begin
					if (s + 2 < vc_now) s += $urandom_range(0, 2);
					load(s, $urandom_range(0, vc_now - 1), $urandom);
				end
			end
			if ($urandom_range(0, 4) == 0) write_vc(11'($urandom_range(0, 2047)));
			if ($urandom_range(0, 9) == 0) read(2'($urandom_range(2, 3)), $urandom);
			push_cmd(cgt_pkg::ModeBuild, 0, 0, 0, 0, $urandom_range(0, 7) == 0);
			n = $urandom_range(5, 30);
			for (int i = 0; i < n; i++) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) read(2'($urandom_range(2, 3)), $urandom);
				else if (pick == 1) push_cmd(cgt_pkg::ModeBuild, 0, 0, 0, 0);
				else if (pick < 8) read(cgt_pkg::ModeRdOff, $urandom_range(0, vc_now + 1));
				else read(cgt_pkg::ModeRdEdg, $urandom_range(0, n + 41));
			end
		end

		wait_idle();
		repeat (64) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#100ms;
		$display("testbench: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

@@ csr_graph_transpose.f @@
sv/cgt_pkg.sv
sv/csr_graph_transpose.sv
bench/testbench.sv
